// File: rtl/pah_pkg.sv
package pah_pkg;

	localparam int HIST_BINS_DEF   = 512;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int SAMPLE_W   = 32;
	localparam int STEP_W     = 31;
	localparam int BIN_IDX_W  = 9;
	localparam int OUT_CNT_W  = 32;
	localparam int FUNC_W     = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] REG_BIN_START = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BIN_END   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BIN_STEP  = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] BIN_START_RST = -32'sd1310720;
	localparam logic signed [SAMPLE_W-1:0] BIN_END_RST   = 32'sd1310720;
	localparam logic [STEP_W-1:0]          BIN_STEP_RST  = 31'd6554;

endpackage

// File: rtl/pah_ifs.sv
interface pah_in_if import pah_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic signed [SAMPLE_W-1:0] sample;
	logic [BIN_IDX_W-1:0]       read_index;

	modport source (output valid, func, sample, read_index, input ready);
	modport sink (input valid, func, sample, read_index, output ready);
endinterface

interface pah_out_if import pah_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 peak_found;
	logic [BIN_IDX_W-1:0] peak_bin;
	logic [OUT_CNT_W-1:0] bin_value;
	logic [OUT_CNT_W-1:0] peak_total;

	modport source (output valid, peak_found, peak_bin, bin_value, peak_total, input ready);
	modport sink (input valid, peak_found, peak_bin, bin_value, peak_total, output ready);
endinterface

interface pah_cfg_if import pah_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/pah_ram.sv
module pah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/peak_amplitude_histogram.sv
// Local-maximum peak histogram. Each sample transaction (func 0) is compared with the
// previous sample; a fall after a rise marks the previous sample as a peak, and a peak
// inside [bin_start, bin_end) increments bin (peak - bin_start) / bin_step, saturated
// at the last bin, along with the total count. The bin counts live in one single-port-
// write RAM with a registered read. A sample that is not a counted peak, and a NOP
// (func 3), go straight to the result; an in-range read passes through the RAM read;
// a counted peak first runs the bit-serial restoring divider that produces one
// quotient bit per cycle, followed by the RAM read-modify-write; when the peak lands
// past the last bin the divider stops after its first pass. A clear, and reset
// itself, sweeps zeros through the RAM one entry per cycle, during which no sample
// is accepted; configuration writes are taken at any time. The result register lets
// the next transaction be accepted while a result waits to be taken.
module peak_amplitude_histogram import pah_pkg::*; #(
	parameter int HIST_BINS   = HIST_BINS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	pah_in_if.sink  samples,
	pah_out_if.source results,
	pah_cfg_if.sink cfg
);

	localparam int AW    = $clog2(HIST_BINS);
	localparam int DW    = STEP_W + AW;
	localparam int CNT_W = $clog2(AW + 1);
	localparam int XW    = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
	localparam logic [AW-1:0] LAST_BIN = AW'(HIST_BINS - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_RD, S_UPD, S_DONE} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [OUT_CNT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] c);
		logic [XW-1:0] ext;
		ext = XW'(c);
		return (ext > XW'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}} : ext[OUT_CNT_W-1:0];
	endfunction

	state_t state_q;

	logic signed [SAMPLE_W-1:0] bin_start_q, bin_end_q;
	logic [STEP_W-1:0]          bin_step_q;

	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       has_prev_q, rising_q;
	logic [COUNT_WIDTH-1:0]     total_q;

	logic [AW-1:0]       clr_addr_q;
	logic                clr_emit_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [DW-1:0]       dsh_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [AW-1:0]       idx_q;
	logic                is_peak_q, is_read_q;

	logic                 res_found_q;
	logic [BIN_IDX_W-1:0] res_bin_q;
	logic [OUT_CNT_W-1:0] res_bval_q;

	logic                 out_valid_q;
	logic                 out_found_q;
	logic [BIN_IDX_W-1:0] out_bin_q;
	logic [OUT_CNT_W-1:0] out_bval_q, out_total_q;

	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                in_range, counted, read_ok, div_ge, out_load;
	logic [SAMPLE_W-1:0] diff_w;
	logic [STEP_W-1:0]   step_eff;
	logic [DW-1:0]       rem_ext;
	logic [AW-1:0]       q_next;

	pah_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(HIST_BINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign samples.ready      = (state_q == S_IDLE);
	assign cfg.ready          = 1'b1;
	assign results.valid      = out_valid_q;
	assign results.peak_found = out_found_q;
	assign results.peak_bin   = out_bin_q;
	assign results.bin_value  = out_bval_q;
	assign results.peak_total = out_total_q;

	always_comb begin
		in_range = (prev_q >= bin_start_q) && (prev_q < bin_end_q);
		counted  = has_prev_q && rising_q && (samples.sample < prev_q) && in_range;
		// Inside the range the offset is non-negative and fits in 32 bits.
		diff_w   = prev_q - bin_start_q;
		step_eff = (bin_step_q == '0) ? STEP_W'(1) : bin_step_q;
		read_ok  = 32'(samples.read_index) < 32'(HIST_BINS);
		rem_ext  = DW'(rem_q);
		div_ge   = rem_ext >= dsh_q;
		q_next   = (idx_q << 1) | AW'(div_ge);
		out_load = (state_q == S_DONE) && (!out_valid_q || results.ready);

		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = sat_inc(ram_rdata);
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			S_RD: ram_re = 1'b1;
			S_UPD: ram_we = is_peak_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			bin_start_q <= BIN_START_RST;
			bin_end_q   <= BIN_END_RST;
			bin_step_q  <= BIN_STEP_RST;
			prev_q      <= '0;
			has_prev_q  <= 1'b0;
			rising_q    <= 1'b0;
			total_q     <= '0;
			clr_addr_q  <= '0;
			clr_emit_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.addr)
					REG_BIN_START: bin_start_q <= cfg.data;
					REG_BIN_END: bin_end_q <= cfg.data;
					REG_BIN_STEP: bin_step_q <= cfg.data[STEP_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_BIN) begin
						state_q    <= clr_emit_q ? S_DONE : S_IDLE;
						clr_emit_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (samples.valid) begin
						is_peak_q   <= 1'b0;
						is_read_q   <= 1'b0;
						res_found_q <= 1'b0;
						res_bin_q   <= '0;
						res_bval_q  <= '0;
						idx_q       <= '0;
						unique case (samples.func)
							FUNC_SAMPLE: begin
								prev_q     <= samples.sample;
								has_prev_q <= 1'b1;
								if (has_prev_q) begin
									if (samples.sample > prev_q) begin
										rising_q <= 1'b1;
									end else if (samples.sample < prev_q) begin
										rising_q <= 1'b0;
									end
								end
								rem_q     <= diff_w;
								dsh_q     <= DW'(step_eff) << AW;
								cnt_q     <= '0;
								is_peak_q <= counted;
								state_q   <= counted ? S_DIV : S_DONE;
							end
							FUNC_READ: begin
								idx_q     <= AW'(samples.read_index);
								is_read_q <= read_ok;
								state_q   <= read_ok ? S_RD : S_DONE;
							end
							FUNC_CLEAR: begin
								prev_q     <= '0;
								has_prev_q <= 1'b0;
								rising_q   <= 1'b0;
								total_q    <= '0;
								clr_addr_q <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							FUNC_NOP: state_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					// The first pass only tests whether the quotient reaches HIST_BINS.
					if (cnt_q == '0) begin
						if (div_ge) begin
							idx_q   <= LAST_BIN;
							state_q <= S_RD;
						end else begin
							dsh_q <= dsh_q >> 1;
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						if (div_ge) begin
							rem_q <= SAMPLE_W'(rem_ext - dsh_q);
						end
						dsh_q <= dsh_q >> 1;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(AW)) begin
							idx_q   <= (q_next > LAST_BIN) ? LAST_BIN : q_next;
							state_q <= S_RD;
						end else begin
							idx_q <= q_next;
						end
					end
				end
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					if (is_peak_q) begin
						total_q     <= sat_inc(total_q);
						res_found_q <= 1'b1;
						res_bin_q   <= BIN_IDX_W'(idx_q);
					end
					if (is_read_q) begin
						res_bval_q <= clip_out(ram_rdata);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_found_q <= res_found_q;
						out_bin_q   <= res_bin_q;
						out_bval_q  <= res_bval_q;
						out_total_q <= clip_out(total_q);
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule
